### src/rlmfb_pkg.sv
`default_nettype none
package rlmfb_pkg;

  // Operation codes carried by an input word
  typedef logic [2:0] op_t;
  localparam op_t OP_SET_COLOUR = 3'd0;
  localparam op_t OP_SET_PLANE  = 3'd1;
  localparam op_t OP_READ_BIT   = 3'd2;
  localparam op_t OP_CLR_PLANE  = 3'd3;
  localparam op_t OP_CLR_ALL    = 3'd4;
  localparam op_t OP_DUMP       = 3'd5;

  // Number of planes that have a colour bit and a mirror bit
  localparam int unsigned COLOUR_PLANES = 3;

  // Which result word the output register takes
  typedef enum logic [1:0] {
    OSEL_SINGLE,
    OSEL_LO,
    OSEL_HI
  } out_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     rd_en;
    logic     wr_en;
    logic     capture_bit;
    logic     clr_plane;
    logic     clr_all;
    logic     pcnt_inc;
    logic     wcnt_inc;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic bad;
    logic pos_ok;
    logic pcnt_last;
    logic wcnt_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### src/rlmfb_ctrl.sv
`default_nettype none
module rlmfb_ctrl
  import rlmfb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_WR,
    S_EMIT,
    S_DRD,
    S_DLO,
    S_DHI
  } state_t;

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Sequence one operation
  always_comb begin
    cmd       = '0;
    cmd.out_sel = OSEL_SINGLE;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_SET_COLOUR: state_nxt = sts.pos_ok ? S_RD : S_EMIT;
          OP_SET_PLANE, OP_READ_BIT: begin
            state_nxt = (sts.pos_ok && !sts.bad) ? S_RD : S_EMIT;
          end
          OP_CLR_PLANE: begin
            cmd.clr_plane = !sts.bad;
            state_nxt     = S_EMIT;
          end
          OP_CLR_ALL: begin
            cmd.clr_all = 1'b1;
            state_nxt   = S_EMIT;
          end
          OP_DUMP: state_nxt = sts.bad ? S_EMIT : S_DRD;
          default: state_nxt = S_EMIT;
        endcase
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (sts.op == OP_READ_BIT) begin
          cmd.capture_bit = 1'b1;
          state_nxt       = S_EMIT;
        end else begin
          cmd.wr_en = 1'b1;
          if (sts.op == OP_SET_COLOUR && !sts.pcnt_last) begin
            cmd.pcnt_inc = 1'b1;
            state_nxt    = S_RD;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DLO;
      end
      S_DLO: begin
        cmd.out_sel = OSEL_LO;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_DHI;
        end
      end
      S_DHI: begin
        cmd.out_sel = OSEL_HI;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.wcnt_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.wcnt_inc = 1'b1;
            state_nxt    = S_DRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### src/rlmfb_dp.sv
`default_nettype none
module rlmfb_dp
  import rlmfb_pkg::*;
#(
  parameter int unsigned NUM_PLANES      = 3,
  parameter int unsigned WORDS_PER_PLANE = 8,
  parameter int unsigned BITS_PER_WORD   = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  input  wire logic [2:0] cfg_mirror_mask,
  input  wire logic [2:0] in_op,
  input  wire logic [1:0] in_plane,
  input  wire logic [3:0] in_bit_pos,
  input  wire logic [2:0] in_word_pos,
  input  wire logic [2:0] in_colour,
  input  wire logic       in_lit,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic [7:0]      out_data_byte,
  output logic            out_read_bit,
  output logic            out_rejected,
  output logic            out_last,
  input  wire cmd_t       cmd,
  output sts_t            sts
);

  localparam int unsigned DEPTH  = NUM_PLANES * WORDS_PER_PLANE;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int unsigned WW     = (WORDS_PER_PLANE > 1) ? $clog2(WORDS_PER_PLANE) : 1;
  localparam logic [4:0]  NP5    = 5'(NUM_PLANES);
  localparam logic [4:0]  NW5    = 5'(WORDS_PER_PLANE);
  localparam logic [4:0]  NB5    = 5'(BITS_PER_WORD);

  // Frame store and per-entry valid bits
  logic [BITS_PER_WORD-1:0] mem [DEPTH];
  logic [DEPTH-1:0]         vld_r;
  logic [BITS_PER_WORD-1:0] rd_data_r;
  logic                     rd_vld_r;

  logic [2:0]  mirror_r;
  op_t         op_r;
  logic [1:0]  plane_r;
  logic [3:0]  bit_r;
  logic [2:0]  word_r;
  logic [2:0]  colour_r;
  logic        lit_r;
  logic [PW-1:0] pcnt_r;
  logic [WW-1:0] wcnt_r;
  logic        rbit_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_bit_r;
  logic        out_rej_r;
  logic        out_last_r;

  logic [3:0]               sel_pl;
  logic                     mirror_bit;
  logic                     named;
  logic                     bad;
  logic                     rej;
  logic [3:0]               word_m;
  logic [ADDR_W-1:0]        addr;
  logic [BITS_PER_WORD-1:0] mask;
  logic [BITS_PER_WORD-1:0] cur_word;
  logic [BITS_PER_WORD-1:0] new_word;
  logic                     new_bit;
  logic                     rd_bit;
  logic [15:0]              word16;

  // Hold the mirror register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= '0;
    end else if (cfg_valid) begin
      mirror_r <= cfg_mirror_mask;
    end
  end

  // Latch the input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      plane_r  <= in_plane;
      bit_r    <= in_bit_pos;
      word_r   <= in_word_pos;
      colour_r <= in_colour;
      lit_r    <= in_lit;
    end
  end

  // Advance plane and word counters, capture the read bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= '0;
      wcnt_r <= '0;
      rbit_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        pcnt_r <= '0;
        wcnt_r <= '0;
        rbit_r <= 1'b0;
      end else begin
        if (cmd.pcnt_inc) pcnt_r <= pcnt_r + 1'b1;
        if (cmd.wcnt_inc) wcnt_r <= wcnt_r + 1'b1;
        if (cmd.capture_bit) rbit_r <= rd_bit;
      end
    end
  end

  // Address the plane in use, mirrored for set and read
  always_comb begin
    sel_pl     = (op_r == OP_SET_COLOUR) ? 4'(pcnt_r) : {2'b00, plane_r};
    mirror_bit = 1'b0;
    named      = 1'b0;
    for (int i = 0; i < COLOUR_PLANES; i++) begin
      if (sel_pl == 4'(i)) begin
        mirror_bit = mirror_r[i];
        named      = colour_r[i];
      end
    end
    word_m = mirror_bit ? (4'(WORDS_PER_PLANE - 1) - {1'b0, word_r}) : {1'b0, word_r};
    if (op_r == OP_DUMP) begin
      addr = ADDR_W'(int'(sel_pl) * WORDS_PER_PLANE + int'(wcnt_r));
    end else begin
      addr = ADDR_W'(int'(sel_pl) * WORDS_PER_PLANE + int'(word_m));
    end
  end

  // Modify the addressed bit
  always_comb begin
    cur_word = rd_vld_r ? rd_data_r : '0;
    rd_bit   = 1'b0;
    for (int i = 0; i < BITS_PER_WORD; i++) begin
      mask[i] = (4'(i) == bit_r);
      rd_bit  = rd_bit | (cur_word[i] & mask[i]);
    end
    new_bit  = (op_r == OP_SET_COLOUR) ? (named & lit_r) : lit_r;
    new_word = new_bit ? (cur_word | mask) : (cur_word & ~mask);
    word16   = 16'(cur_word);
  end

  // Write and read the store
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= new_word;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  // Track written entries, drop them on clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[addr];
      end
      if (cmd.wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (cmd.clr_all) begin
        vld_r <= '0;
      end else if (cmd.clr_plane) begin
        for (int p = 0; p < NUM_PLANES; p++) begin
          for (int w = 0; w < WORDS_PER_PLANE; w++) begin
            if (sel_pl == 4'(p)) vld_r[p * WORDS_PER_PLANE + w] <= 1'b0;
          end
        end
      end
    end
  end

  // Reject a bad plane on the plane-addressed operations
  assign bad = ({3'b000, plane_r} >= NP5);
  assign rej = bad && (op_r == OP_SET_PLANE || op_r == OP_READ_BIT ||
                       op_r == OP_CLR_PLANE || op_r == OP_DUMP);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        OSEL_LO: begin
          out_byte_r <= word16[7:0];
          out_bit_r  <= 1'b0;
          out_rej_r  <= 1'b0;
          out_last_r <= 1'b0;
        end
        OSEL_HI: begin
          out_byte_r <= word16[15:8];
          out_bit_r  <= 1'b0;
          out_rej_r  <= 1'b0;
          out_last_r <= sts.wcnt_last;
        end
        default: begin
          out_byte_r <= '0;
          out_bit_r  <= rbit_r;
          out_rej_r  <= rej;
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_byte_r;
  assign out_read_bit  = out_bit_r;
  assign out_rejected  = out_rej_r;
  assign out_last      = out_last_r;

  // Status to the controller
  assign sts.op        = op_r;
  assign sts.bad       = bad;
  assign sts.pos_ok    = ({1'b0, bit_r} < NB5) && ({2'b00, word_r} < NW5);
  assign sts.pcnt_last = (pcnt_r == PW'(NUM_PLANES - 1));
  assign sts.wcnt_last = (wcnt_r == WW'(WORDS_PER_PLANE - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule
`default_nettype wire

### src/rgb_led_matrix_frame_buffer.sv
`default_nettype none
// Channel  Direction  Handshake               Payload
// cfg      in         cfg_valid / cfg_ready   cfg_mirror_mask
// in       in         in_valid / in_ready     in_op, in_plane, in_bit_pos, in_word_pos,
//                                              in_colour, in_lit
// out      out        out_valid / out_ready   out_data_byte, out_read_bit, out_rejected,
//                                              out_last
//
// One word at a time through the controller; the store has one port, read then written.
// Set one plane or read a bit: decode, read, write or capture, emit; set by colour reads and
// writes each plane in turn; rejected or out-of-range ops, clears and other ops: decode, emit;
// a dump reads each word of the plane and emits its low byte, then its high byte.
// Reset clears the per-entry valid bits; there is no clearing pass.
// A stalled output holds the controller in its emit or dump byte step; the next input
// word is taken while the last result of the previous one still waits in the output register.
module rgb_led_matrix_frame_buffer
  import rlmfb_pkg::*;
#(
  parameter int unsigned NUM_PLANES      = 3,
  parameter int unsigned WORDS_PER_PLANE = 8,
  parameter int unsigned BITS_PER_WORD   = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_mirror_mask,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_op,
  input  wire logic [1:0] in_plane,
  input  wire logic [3:0] in_bit_pos,
  input  wire logic [2:0] in_word_pos,
  input  wire logic [2:0] in_colour,
  input  wire logic       in_lit,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_data_byte,
  output logic            out_read_bit,
  output logic            out_rejected,
  output logic            out_last
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rlmfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rlmfb_dp #(
    .NUM_PLANES      (NUM_PLANES),
    .WORDS_PER_PLANE (WORDS_PER_PLANE),
    .BITS_PER_WORD   (BITS_PER_WORD)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_mirror_mask (cfg_mirror_mask),
    .in_op           (in_op),
    .in_plane        (in_plane),
    .in_bit_pos      (in_bit_pos),
    .in_word_pos     (in_word_pos),
    .in_colour       (in_colour),
    .in_lit          (in_lit),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_data_byte   (out_data_byte),
    .out_read_bit    (out_read_bit),
    .out_rejected    (out_rejected),
    .out_last        (out_last),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
`default_nettype wire
